// ----- rtl/srt_pkg.sv -----
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants of the spiral route transposition block.
// ----------------------------------------------------------------------------
package srt_pkg;

    // character and configuration widths
    localparam int CHAR_W  = 7;
    localparam int GEOM_W  = 4;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 4;

    // padding letter 'X'
    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h58;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_COLS = 2'd2;

    // reset values of the configuration registers
    localparam logic [GEOM_W-1:0] ROWS_RST = 4'd4;
    localparam logic [GEOM_W-1:0] COLS_RST = 4'd4;

    // spiral walk directions
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic seq_init;  // restart linear counter and spiral walker
        logic rd;        // issue one RAM read and advance the sequence
        logic perm;      // read belongs to the permute pass
        logic done;      // burst finished, clear fill count
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mode;       // 1 decrypt
        logic seq_done;   // every cell of the grid issued
        logic s1_free;    // read stage can take a new read this cycle
        logic pipe_empty; // nothing in read stage or output register
    } t_status;

endpackage

// ----- rtl/spiral_route_transposition.sv -----
// ----------------------------------------------------------------------------
// spiral_route_transposition
// Spiral route transposition cipher: letters fill a rows x cols grid, the
// message end pads with 'X'; encrypt reads the grid along the spiral route.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_char, i_in_last
//  out     | output    | o_out_valid / i_out_stall  | o_out_char, o_out_last
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// The input takes one byte a cycle while not stalled; the grid RAM takes one write a cycle.
// After the last byte the burst gives one character a cycle while i_out_stall
// is low (rows*cols transfers), behind a registered RAM read and the output
// register; decrypt first runs a permute pass from grid RAM to permute RAM.
// Input is stalled from the last byte until the burst is fully taken.
// Synchronous active-low reset clears control state and configuration.
// ----------------------------------------------------------------------------
module spiral_route_transposition #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [srt_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [srt_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_in_char,
    input  logic                       i_in_last,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [srt_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_out_last
);

    import srt_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    srt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    srt_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_char   (i_in_char),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_char  (o_out_char),
        .o_out_last  (o_out_last)
    );

endmodule

// ----- rtl/srt_ram.sv -----
// ----------------------------------------------------------------------------
// srt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/srt_spiral.sv -----
// ----------------------------------------------------------------------------
// srt_spiral
// Spiral route walker: one cell address per step, down the left column,
// along the bottom, up the right column, along the top, then inward.
// ----------------------------------------------------------------------------
module srt_spiral #(
    parameter int ADDR_W = 6
) (
    input  logic                      i_clk,
    input  logic                      i_init,
    input  logic                      i_step,
    input  logic [srt_pkg::GEOM_W-1:0] i_rows,
    input  logic [srt_pkg::GEOM_W-1:0] i_cols,
    output logic [ADDR_W-1:0]         o_addr
);

    import srt_pkg::*;

    localparam int XW = ADDR_W + GEOM_W;

    logic [GEOM_W-1:0] r_r, r_c, r_t, r_b, r_l, r_rt;
    logic [GEOM_W-1:0] n_r, n_c, n_t, n_b, n_l, n_rt;
    logic [1:0]        r_dir, n_dir;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] w_plus1, w_minus1, w_pcols, w_mcols;

    // address neighbors of the current cell
    assign w_plus1  = r_addr + ADDR_W'(1);
    assign w_minus1 = r_addr - ADDR_W'(1);
    assign w_pcols  = ADDR_W'(XW'(r_addr) + XW'(i_cols));
    assign w_mcols  = ADDR_W'(XW'(r_addr) - XW'(i_cols));

    // next cell: move along the edge, or shrink the bound and turn
    always_comb begin
        n_r = r_r; n_c = r_c; n_t = r_t; n_b = r_b; n_l = r_l; n_rt = r_rt;
        n_dir = r_dir;
        n_addr = r_addr;
        case (r_dir)
            DIR_DOWN: begin
                if (r_r < r_b) begin
                    n_r = r_r + 4'd1; n_addr = w_pcols;
                end else begin
                    n_l = r_l + 4'd1; n_c = r_c + 4'd1;
                    n_dir = DIR_RIGHT; n_addr = w_plus1;
                end
            end
            DIR_RIGHT: begin
                if (r_c < r_rt) begin
                    n_c = r_c + 4'd1; n_addr = w_plus1;
                end else begin
                    n_b = r_b - 4'd1; n_r = r_r - 4'd1;
                    n_dir = DIR_UP; n_addr = w_mcols;
                end
            end
            DIR_UP: begin
                if (r_r > r_t) begin
                    n_r = r_r - 4'd1; n_addr = w_mcols;
                end else begin
                    n_rt = r_rt - 4'd1; n_c = r_c - 4'd1;
                    n_dir = DIR_LEFT; n_addr = w_minus1;
                end
            end
            default: begin
                if (r_c > r_l) begin
                    n_c = r_c - 4'd1; n_addr = w_minus1;
                end else begin
                    n_t = r_t + 4'd1; n_r = r_r + 4'd1;
                    n_dir = DIR_DOWN; n_addr = w_pcols;
                end
            end
        endcase
    end

    // walker registers
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_r <= '0; r_c <= '0; r_t <= '0; r_l <= '0;
            r_b <= i_rows - 4'd1;
            r_rt <= i_cols - 4'd1;
            r_dir <= DIR_DOWN;
            r_addr <= '0;
        end else if (i_step) begin
            r_r <= n_r; r_c <= n_c; r_t <= n_t; r_b <= n_b;
            r_l <= n_l; r_rt <= n_rt;
            r_dir <= n_dir;
            r_addr <= n_addr;
        end
    end

    assign o_addr = r_addr;

endmodule

// ----- rtl/srt_datapath.sv -----
// ----------------------------------------------------------------------------
// srt_datapath
// Configuration registers, letter filter, grid and permute RAMs, sequence
// counters and the read / output pipeline.
// ----------------------------------------------------------------------------
module srt_datapath #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [srt_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [srt_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic [7:0]                 i_in_char,
    input  logic                       i_out_stall,
    input  srt_pkg::t_cmd              i_cmd,
    output srt_pkg::t_status           o_status,
    output logic                       o_out_valid,
    output logic [srt_pkg::CHAR_W-1:0] o_out_char,
    output logic                       o_out_last
);

    import srt_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(CELLS + 1);

    // configuration
    logic              r_mode;
    logic [GEOM_W-1:0] r_rows_cfg, r_cols_cfg;
    logic [GEOM_W-1:0] w_rows, w_cols;
    logic [CW-1:0]     w_total;

    // fill and sequencing
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_k;
    logic [AW-1:0]     w_sp_addr;
    logic [7:0]        w_up;
    logic              w_letter;
    logic              w_store;
    logic              w_last_k;

    // RAM ports
    logic              w_a_re, w_b_re;
    logic [AW-1:0]     w_a_raddr;
    logic [CHAR_W-1:0] w_a_rdata, w_b_rdata;

    // permute write stage
    logic              r_pw_vld;
    logic              r_pw_pad;
    logic [AW-1:0]     r_pw_addr;

    // emit read stage and output register
    logic              r_s1_vld, r_s1_pad, r_s1_last, r_s1_src;
    logic [CHAR_W-1:0] w_s1_char;
    logic              w_out_free, w_s1_move, w_emit_rd;
    logic              r_o_valid, r_o_last;
    logic [CHAR_W-1:0] r_o_char;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_rows_cfg <= ROWS_RST;
            r_cols_cfg <= COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE: r_mode     <= i_cfg_data[0];
                CFG_ROWS: r_rows_cfg <= i_cfg_data;
                CFG_COLS: r_cols_cfg <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // grid size in use, clamped to 1..max
    always_comb begin
        w_rows = r_rows_cfg;
        if (r_rows_cfg == '0) w_rows = 4'd1;
        else if (32'(r_rows_cfg) > MAX_ROWS) w_rows = GEOM_W'(MAX_ROWS);
        w_cols = r_cols_cfg;
        if (r_cols_cfg == '0) w_cols = 4'd1;
        else if (32'(r_cols_cfg) > MAX_COLS) w_cols = GEOM_W'(MAX_COLS);
    end

    assign w_total = CW'(w_rows) * CW'(w_cols);

    // letter filter: fold lower case, keep A..Z
    assign w_up     = (i_in_char >= 8'h61 && i_in_char <= 8'h7A) ? i_in_char - 8'h20
                                                                  : i_in_char;
    assign w_letter = (w_up >= 8'h41) && (w_up <= 8'h5A);
    assign w_store  = i_cmd.accept && w_letter && (r_fill < w_total);

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.done) begin
            r_fill <= '0;
        end else if (w_store) begin
            r_fill <= r_fill + CW'(1);
        end
    end

    // linear cell counter, runs with the walker
    always_ff @(posedge i_clk) begin
        if (i_cmd.seq_init) begin
            r_k <= '0;
        end else if (i_cmd.rd) begin
            r_k <= r_k + CW'(1);
        end
    end

    assign w_last_k = (r_k == w_total - CW'(1));

    srt_spiral #(
        .ADDR_W (AW)
    ) u_spiral (
        .i_clk  (i_clk),
        .i_init (i_cmd.seq_init),
        .i_step (i_cmd.rd),
        .i_rows (w_rows),
        .i_cols (w_cols),
        .o_addr (w_sp_addr)
    );

    // grid RAM: letters in arrival order
    assign w_emit_rd = i_cmd.rd && !i_cmd.perm;
    assign w_a_re    = (i_cmd.rd && i_cmd.perm) || (w_emit_rd && !r_mode);
    assign w_a_raddr = i_cmd.perm ? r_k[AW-1:0] : w_sp_addr;

    srt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (w_up[CHAR_W-1:0]),
        .i_re    (w_a_re),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    // permute pass: grid cell k goes to spiral cell k, padded past the fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw_vld <= 1'b0;
        end else begin
            r_pw_vld <= i_cmd.rd && i_cmd.perm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd && i_cmd.perm) begin
            r_pw_addr <= w_sp_addr;
            r_pw_pad  <= (r_k >= r_fill);
        end
    end

    assign w_b_re = w_emit_rd && r_mode;

    srt_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_perm (
        .i_clk   (i_clk),
        .i_we    (r_pw_vld),
        .i_waddr (r_pw_addr),
        .i_wdata (r_pw_pad ? PAD_CHAR : w_a_rdata),
        .i_re    (w_b_re),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_b_rdata)
    );

    // emit read stage
    assign w_out_free = !r_o_valid || !i_out_stall;
    assign w_s1_move  = r_s1_vld && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_emit_rd) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_rd) begin
            r_s1_src  <= r_mode;
            r_s1_pad  <= !r_mode && (CW'(w_sp_addr) >= r_fill);
            r_s1_last <= w_last_k;
        end
    end

    assign w_s1_char = r_s1_pad ? PAD_CHAR : (r_s1_src ? w_b_rdata : w_a_rdata);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_o_char <= w_s1_char;
            r_o_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_char  = r_o_char;
    assign o_out_last  = r_o_last;

    // status to controller
    assign o_status.mode       = r_mode;
    assign o_status.seq_done   = (r_k == w_total);
    assign o_status.s1_free    = !r_s1_vld || w_s1_move;
    assign o_status.pipe_empty = !r_s1_vld && !r_o_valid;

endmodule

// ----- rtl/srt_ctrl.sv -----
// ----------------------------------------------------------------------------
// srt_ctrl
// Controller: message fill, permute pass for decrypt, output burst.
// ----------------------------------------------------------------------------
module srt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  srt_pkg::t_status i_status,
    output srt_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);

    import srt_pkg::*;

    localparam logic [1:0] S_FILL = 2'd0;
    localparam logic [1:0] S_PERM = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_FILL: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.seq_init = 1'b1;
                    n_state = i_status.mode ? S_PERM : S_EMIT;
                end
            end
            S_PERM: begin
                o_cmd.perm = 1'b1;
                if (!i_status.seq_done) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    o_cmd.seq_init = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.rd = !i_status.seq_done && i_status.s1_free;
                if (i_status.seq_done && i_status.pipe_empty) begin
                    o_cmd.done = 1'b1;
                    n_state = S_FILL;
                end
            end
            default: n_state = S_FILL;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_FILL);

endmodule
